/* rtl/decimal_number_token_parser_core_assert.svh */
// ----------------------------------------------------------------------------
// assertion macros for the decimal number token parser
// concurrent checks in simulation, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef DECIMAL_NUMBER_TOKEN_PARSER_CORE_ASSERT_SVH
`define DECIMAL_NUMBER_TOKEN_PARSER_CORE_ASSERT_SVH
`ifndef SYNTH
`define DNP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("dnp assertion failed");
`define DNP_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("dnp forbidden condition seen");
`else
`define DNP_ASSERT(lbl, clk, rstn, prop)
`define DNP_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* rtl/dnp_pkg.sv */
// ----------------------------------------------------------------------------
// dnp_pkg
// widths, character codes, descriptor types and the power-of-ten table
// ----------------------------------------------------------------------------
package dnp_pkg;

  localparam int CharW         = 8;
  localparam int IntW          = 63;
  localparam int FracBits      = 32;
  localparam int FracAccW      = 60;
  localparam int MaxChars      = 4096;
  localparam int PosW          = $clog2(MaxChars + 1);
  localparam int MaxFracDigits = 18;
  localparam int CntW          = 5;
  localparam int ZeroW         = 13;
  localparam int ZexpW         = 4;
  localparam int ZeroDivLimit  = 10;
  localparam int IterW         = $clog2(FracBits);
  localparam int QueueDepth    = 2;
  localparam int QueuePtrW     = $clog2(QueueDepth);
  localparam int QueueCntW     = $clog2(QueueDepth + 1);

  localparam logic [ZeroW-1:0] ZeroMax = {ZeroW{1'b1}};
  localparam logic [IntW-1:0]  IntMax  = {IntW{1'b1}};

  localparam logic [CharW-1:0] ChZero  = 8'd48;
  localparam logic [CharW-1:0] ChNine  = 8'd57;
  localparam logic [CharW-1:0] ChDot   = 8'd46;
  localparam logic [CharW-1:0] ChSpace = 8'd32;
  localparam logic [CharW-1:0] ChTab   = 8'd9;
  localparam logic [CharW-1:0] ChCr    = 8'd13;

  // one finished number, as handed from the parser to the divider
  typedef struct packed {
    logic                ok;
    logic                is_int;
    logic [IntW-1:0]     int_part;
    logic [PosW-1:0]     consumed;
    logic                ovf;
    logic                div_en;
    logic [FracAccW-1:0] frac_acc;
    logic [CntW-1:0]     frac_cnt;
    logic [ZexpW-1:0]    zero_exp;
  } desc_t;

  typedef struct packed {
    logic                ok;
    logic                is_int;
    logic [IntW-1:0]     int_part;
    logic [FracBits-1:0] frac;
    logic [PosW-1:0]     consumed;
    logic                ovf;
  } res_t;

  function automatic logic [FracAccW-1:0] pow10(input logic [CntW-1:0] e);
    logic [FracAccW-1:0] v;
    case (e)
      5'd0:    v = 60'd1;
      5'd1:    v = 60'd10;
      5'd2:    v = 60'd100;
      5'd3:    v = 60'd1000;
      5'd4:    v = 60'd10000;
      5'd5:    v = 60'd100000;
      5'd6:    v = 60'd1000000;
      5'd7:    v = 60'd10000000;
      5'd8:    v = 60'd100000000;
      5'd9:    v = 60'd1000000000;
      5'd10:   v = 60'd10000000000;
      5'd11:   v = 60'd100000000000;
      5'd12:   v = 60'd1000000000000;
      5'd13:   v = 60'd10000000000000;
      5'd14:   v = 60'd100000000000000;
      5'd15:   v = 60'd1000000000000000;
      5'd16:   v = 60'd10000000000000000;
      5'd17:   v = 60'd100000000000000000;
      5'd18:   v = 60'd1000000000000000000;
      default: v = 60'd1;
    endcase
    return v;
  endfunction

endpackage

/* rtl/dnp_queue.sv */
// ----------------------------------------------------------------------------
// dnp_queue
// two-entry descriptor queue between the parser and the divider
// ----------------------------------------------------------------------------
`include "decimal_number_token_parser_core_assert.svh"

module dnp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dnp_pkg::desc_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output dnp_pkg::desc_t data_o
);
  import dnp_pkg::*;

  desc_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `DNP_NEVER(a_queue_overrun, clk_i, rst_ni, push_i && full_o)
  `DNP_NEVER(a_queue_underrun, clk_i, rst_ni, pop_i && empty_o)
  `DNP_ASSERT(a_queue_count_range, clk_i, rst_ni, cnt_q <= QueueCntW'(QueueDepth))

endmodule

/* rtl/dnp_front.sv */
// ----------------------------------------------------------------------------
// dnp_front
// character-level parser: whitespace, integer digits, dot, zeros, fraction
// ----------------------------------------------------------------------------
module dnp_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [dnp_pkg::CharW-1:0] char_code_i,
  input  logic                      last_char_i,
  input  logic                      full_i,
  output logic                      push_o,
  output dnp_pkg::desc_t            desc_o
);
  import dnp_pkg::*;

  localparam logic [2:0] PhStart = 3'd0;
  localparam logic [2:0] PhInt   = 3'd1;
  localparam logic [2:0] PhDot   = 3'd2;
  localparam logic [2:0] PhFrac  = 3'd3;
  localparam logic [2:0] PhDone  = 3'd4;

  logic [2:0]          phase_q, phase_d, ph_u;
  logic [IntW-1:0]     int_q, int_d, int_u;
  logic [FracAccW-1:0] frac_q, frac_d, frac_u;
  logic [ZeroW-1:0]    zc_q, zc_d, zc_u;
  logic [CntW-1:0]     cnt_q, cnt_d, cnt_u;
  logic [PosW-1:0]     pos_q, pos_d, pos_u;
  logic                ovf_q, ovf_d, ovf_u;

  logic                is_dig, is_ws, fits, consume, emit, accept, ok_u;
  logic [3:0]          dval;
  logic [IntW+3:0]     int_x10;
  logic [FracAccW-1:0] frac_x10;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_dig  = (char_code_i >= ChZero) && (char_code_i <= ChNine);
  assign is_ws   = (char_code_i == ChSpace) ||
                   ((char_code_i >= ChTab) && (char_code_i <= ChCr));
  assign dval    = char_code_i[3:0];
  assign int_x10 = {1'b0, int_q, 3'b000} + {3'b000, int_q, 1'b0} + (IntW + 4)'(dval);
  assign frac_x10 = {frac_q[FracAccW-4:0], 3'b000} + {frac_q[FracAccW-2:0], 1'b0}
                  + FracAccW'(dval);

  always_comb begin
    ph_u    = phase_q;
    int_u   = int_q;
    frac_u  = frac_q;
    zc_u    = zc_q;
    cnt_u   = cnt_q;
    ovf_u   = ovf_q;
    fits    = 1'b1;
    consume = 1'b0;
    unique case (phase_q)
      PhStart: begin
        if (is_ws) begin
          consume = 1'b1;
        end else if (is_dig) begin
          int_u   = IntW'(dval);
          ph_u    = PhInt;
          consume = 1'b1;
        end else begin
          fits = 1'b0;
        end
      end
      PhInt: begin
        if (char_code_i == ChDot) begin
          ph_u    = PhDot;
          consume = 1'b1;
        end else if (is_dig) begin
          // saturate once the value would pass the top of the range
          if (int_x10[IntW+3:IntW] != '0) begin
            int_u = IntMax;
            ovf_u = 1'b1;
          end else begin
            int_u = int_x10[IntW-1:0];
          end
          consume = 1'b1;
        end else begin
          fits = 1'b0;
        end
      end
      PhDot: begin
        if (char_code_i == ChZero) begin
          if (zc_q != ZeroMax) zc_u = zc_q + 1'b1;
          consume = 1'b1;
        end else if (is_dig) begin
          frac_u  = FracAccW'(dval);
          cnt_u   = CntW'(1);
          ph_u    = PhFrac;
          consume = 1'b1;
        end else begin
          fits = 1'b0;
        end
      end
      PhFrac: begin
        if (is_dig) begin
          if (cnt_q < CntW'(MaxFracDigits)) begin
            frac_u = frac_x10;
            cnt_u  = cnt_q + 1'b1;
          end else begin
            ovf_u = 1'b1;
          end
          consume = 1'b1;
        end else begin
          fits = 1'b0;
        end
      end
      default: begin
        fits = 1'b1;
      end
    endcase
  end

  assign pos_u = (consume && (pos_q < PosW'(MaxChars))) ? pos_q + 1'b1 : pos_q;
  assign emit  = (phase_q != PhDone) && (!fits || last_char_i);
  assign push_o = accept && emit;

  assign ok_u = (ph_u == PhInt) || (ph_u == PhFrac) || ((ph_u == PhDot) && (zc_u != '0));

  always_comb begin
    desc_o          = '0;
    desc_o.ok       = ok_u;
    desc_o.is_int   = (ph_u == PhInt);
    desc_o.int_part = ok_u ? int_u : '0;
    desc_o.consumed = ok_u ? pos_u : '0;
    desc_o.ovf      = ok_u && ovf_u;
    // the divide runs only where the fraction can be nonzero
    desc_o.div_en   = ok_u && (ph_u != PhInt) && (cnt_u != '0) &&
                      (zc_u < ZeroW'(ZeroDivLimit));
    desc_o.frac_acc = frac_u;
    desc_o.frac_cnt = cnt_u;
    desc_o.zero_exp = zc_u[ZexpW-1:0];
  end

  always_comb begin
    phase_d = phase_q;
    int_d   = int_q;
    frac_d  = frac_q;
    zc_d    = zc_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    ovf_d   = ovf_q;
    if (accept) begin
      if (last_char_i) begin
        phase_d = PhStart;
        int_d   = '0;
        frac_d  = '0;
        zc_d    = '0;
        cnt_d   = '0;
        pos_d   = '0;
        ovf_d   = 1'b0;
      end else if (phase_q != PhDone) begin
        phase_d = emit ? PhDone : ph_u;
        int_d   = int_u;
        frac_d  = frac_u;
        zc_d    = zc_u;
        cnt_d   = cnt_u;
        pos_d   = pos_u;
        ovf_d   = ovf_u;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      int_q   <= '0;
      frac_q  <= '0;
      zc_q    <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      int_q   <= int_d;
      frac_q  <= frac_d;
      zc_q    <= zc_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

/* rtl/dnp_back.sv */
// ----------------------------------------------------------------------------
// dnp_back
// bit-serial fraction divider and result register
// ----------------------------------------------------------------------------
`include "decimal_number_token_parser_core_assert.svh"

module dnp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  dnp_pkg::desc_t desc_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dnp_pkg::res_t  res_o
);
  import dnp_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv1 = 2'd1;
  localparam logic [1:0] StDiv2 = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0]          state_q, state_d;
  desc_t               cur_q, cur_d;
  logic [FracAccW-1:0] den_q, den_d, rem_q, rem_d;
  logic [FracBits-1:0] quo_q, quo_d;
  logic [IterW-1:0]    iter_q, iter_d;
  res_t                res_q, res_d;
  logic                out_valid_q, out_valid_d;

  logic                out_free, load_out, ge;
  logic [FracAccW:0]   shifted, diff;
  res_t                res_new;

  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = (state_q == StIdle) && !empty_i && (desc_i.div_en || out_free);

  // one restoring step: bring in the top quotient bit, subtract if it fits
  assign shifted = {rem_q, quo_q[FracBits-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = !diff[FracAccW];

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    den_d    = den_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    iter_d   = iter_q;
    load_out = 1'b0;
    res_new  = '0;
    unique case (state_q)
      StIdle: begin
        if (pop_o) begin
          cur_d = desc_i;
          if (desc_i.div_en) begin
            den_d   = pow10(desc_i.frac_cnt);
            rem_d   = desc_i.frac_acc;
            quo_d   = '0;
            iter_d  = '0;
            state_d = StDiv1;
          end else begin
            load_out          = 1'b1;
            res_new.ok        = desc_i.ok;
            res_new.is_int    = desc_i.is_int;
            res_new.int_part  = desc_i.int_part;
            res_new.consumed  = desc_i.consumed;
            res_new.ovf       = desc_i.ovf;
          end
        end
      end
      StDiv1, StDiv2: begin
        rem_d  = ge ? diff[FracAccW-1:0] : shifted[FracAccW-1:0];
        quo_d  = {quo_q[FracBits-2:0], ge};
        iter_d = iter_q + 1'b1;
        if (iter_q == IterW'(FracBits - 1)) begin
          if ((state_q == StDiv1) && (cur_q.zero_exp != '0)) begin
            // second pass scales down by the zeros after the dot
            den_d   = pow10(CntW'(cur_q.zero_exp));
            rem_d   = '0;
            iter_d  = '0;
            state_d = StDiv2;
          end else begin
            state_d = StFin;
          end
        end
      end
      StFin: begin
        if (out_free) begin
          load_out         = 1'b1;
          res_new.ok       = cur_q.ok;
          res_new.is_int   = cur_q.is_int;
          res_new.int_part = cur_q.int_part;
          res_new.frac     = quo_q;
          res_new.consumed = cur_q.consumed;
          res_new.ovf      = cur_q.ovf;
          state_d          = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    res_d       = res_q;
    out_valid_d = out_valid_q;
    if (load_out) begin
      res_d       = res_new;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      iter_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      iter_q      <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    res_q <= res_d;
  end

  `DNP_ASSERT(a_div_den_nonzero, clk_i, rst_ni, (state_q == StDiv1 || state_q == StDiv2) |-> (den_q != '0))
  `DNP_ASSERT(a_div_rem_below_den, clk_i, rst_ni, (state_q == StDiv1 || state_q == StDiv2) |-> (rem_q < den_q))
  `DNP_ASSERT(a_div_only_when_needed, clk_i, rst_ni, (state_q == StDiv1) |-> cur_q.div_en)

endmodule

/* rtl/decimal_number_token_parser_core.sv */
// result path: the ending beat's number is written into the queue; integers, failures,
//   zero fractions and fractions with ten or more zeros after the dot go from the queue
//   head to the result register; other fractions run one or two divide passes first
// throughput: one character per cycle while the two-entry number queue has room
// reset: rst_ni is asynchronous, active low; parser, queue and divider return to idle
// ----------------------------------------------------------------------------
// decimal_number_token_parser_core
// streams text one byte a beat and returns one parsed number result per buffer
// token, with the fraction given as unsigned 0.32 fixed point
// ----------------------------------------------------------------------------
module decimal_number_token_parser_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // character channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [dnp_pkg::CharW-1:0]    char_code_i,
  input  logic                         last_char_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         ok_o,
  output logic                         is_integer_o,
  output logic [dnp_pkg::IntW-1:0]     integer_part_o,
  output logic [dnp_pkg::FracBits-1:0] fraction_fixed_o,
  output logic [dnp_pkg::PosW-1:0]     consumed_o,
  output logic                         overflow_o
);
  import dnp_pkg::*;

  // front to queue
  logic  push;
  desc_t push_desc;
  // queue to back
  logic  q_full, q_empty, pop;
  desc_t head_desc;
  res_t  res;

  // parser: classifies each beat and accumulates digits; it only stalls when the
  // queue is full, so a long fraction divide holds up the character stream only then
  dnp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .full_i      (q_full),
    .push_o      (push),
    .desc_o      (push_desc)
  );

  // short decoupling queue of finished numbers
  dnp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_desc),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .data_o  (head_desc)
  );

  // divider: floor(digits * 2^32 / 10^count), then divided again by 10^zeros;
  // the result register parts it from the output handshake
  dnp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .desc_i      (head_desc),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign ok_o             = res.ok;
  assign is_integer_o     = res.is_int;
  assign integer_part_o   = res.int_part;
  assign fraction_fixed_o = res.frac;
  assign consumed_o       = res.consumed;
  assign overflow_o       = res.ovf;

endmodule
